/* hw/rtl/lfs_pkg.sv */
// Package for the line follower steering block.
// Holds the row geometry, field widths, register indexes and reset values.
// No dependencies.
package lfs_pkg;

    localparam int ROW_PIXELS = 320;
    localparam int HALF_ROW   = ROW_PIXELS / 2;
    localparam int POS_W      = $clog2(ROW_PIXELS + 1);

    localparam int BRIGHT_W   = 8;
    localparam int TAPE_W     = 10;
    localparam int GAIN_W     = 16;
    localparam int SPEED_W    = 8;
    localparam int SUM_W      = 20;
    localparam int OUT_W      = 9;

    localparam int PROD_W     = SUM_W + GAIN_W + 1;
    localparam int STEER_W    = PROD_W - GAIN_W;
    localparam int WHEEL_W    = STEER_W + 1;
    localparam int CMP_W      = (POS_W + 1 > TAPE_W) ? POS_W + 1 : TAPE_W;

    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_WHITE_THRESHOLD = 3'd0,
        REG_TAPE_WIDTH      = 3'd1,
        REG_STEER_GAIN      = 3'd2,
        REG_BASE_SPEED      = 3'd3,
        REG_SPEED_LIMIT     = 3'd4
    } reg_idx_t;

    localparam logic [BRIGHT_W-1:0] WHITE_THRESHOLD_RST = 8'd100;
    localparam logic [TAPE_W-1:0]   TAPE_WIDTH_RST      = 10'd60;
    localparam logic [GAIN_W-1:0]   STEER_GAIN_RST      = 16'd164;
    localparam logic [SPEED_W-1:0]  BASE_SPEED_RST      = 8'd40;
    localparam logic [SPEED_W-1:0]  SPEED_LIMIT_RST     = 8'd150;

endpackage

/* hw/rtl/line_follow_steering_top.sv */
// Top level of the line follower steering block.
// Depends on lfs_pkg for widths, row geometry and register indexes.
//
// Usage: pixels of one camera row enter on the s_ channel, one item per
// pixel, brightness in s_tdata and s_tlast on the last pixel of the row.
// Each row gives one item on the m_ channel: left and right wheel speeds
// in m_tdata and the reversing flag in m_tuser. Registers are written over
// the APB-style port; the user must write them only while the block is idle,
// as the block itself does not enforce it. Throughput is one pixel per cycle
// while the input is not stalled. The edge that takes the last pixel of a row
// closes the row sums into stage 1, stage 2 then registers the gain product,
// the output register takes the clamped speeds and m_tvalid rises with it.
// Reset clears the row sums and the pipeline and loads the default
// register values. When the receiver stalls, results wait in the output
// register and the two stages behind it; the input stalls only when
// all three are full.
module line_follow_steering_top
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [7:0] pixel_brightness
    input  logic                            s_tlast,  // row_end

    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,  // [8:0] left_speed, [17:9] right_speed
    output logic                            m_tuser,  // reversing

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lfs_pkg::ADDR_W-1:0]      paddr,
    input  logic [lfs_pkg::DATA_W-1:0]      pwdata,
    output logic [lfs_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);

    logic [lfs_pkg::BRIGHT_W-1:0] white_threshold_reg;
    logic [lfs_pkg::TAPE_W-1:0]   tape_width_reg;
    logic [lfs_pkg::GAIN_W-1:0]   steer_gain_reg;
    logic [lfs_pkg::SPEED_W-1:0]  base_speed_reg;
    logic [lfs_pkg::SPEED_W-1:0]  speed_limit_reg;

    logic                         cfg_write;
    lfs_pkg::reg_idx_t            cfg_idx;

    logic [lfs_pkg::POS_W-1:0]    pos_reg;
    logic [lfs_pkg::POS_W-1:0]    pos_next;
    logic [lfs_pkg::POS_W-1:0]    count_reg;
    logic [lfs_pkg::POS_W-1:0]    count_next;
    logic signed [lfs_pkg::SUM_W-1:0] sum_reg;
    logic signed [lfs_pkg::SUM_W-1:0] sum_next;
    logic signed [lfs_pkg::SUM_W-1:0] offset;
    logic                         pixel_white;
    logic                         in_row;
    logic                         in_accept;

    logic                         s1_valid_reg;
    logic signed [lfs_pkg::SUM_W-1:0] s1_sum_reg;
    logic                         s1_lost_reg;
    logic                         s1_lost_next;

    logic                         s2_valid_reg;
    logic signed [lfs_pkg::PROD_W-1:0] s2_prod_reg;
    logic                         s2_lost_reg;

    logic                         out_valid_reg;
    logic [lfs_pkg::OUT_W-1:0]    left_reg;
    logic [lfs_pkg::OUT_W-1:0]    right_reg;
    logic                         rev_reg;

    logic                         out_ready;
    logic                         s2_ready;
    logic                         s1_ready;

    logic signed [lfs_pkg::STEER_W-1:0] steer;
    logic signed [lfs_pkg::WHEEL_W-1:0] base_s;
    logic signed [lfs_pkg::WHEEL_W-1:0] lim_s;
    logic signed [lfs_pkg::WHEEL_W-1:0] left_raw;
    logic signed [lfs_pkg::WHEEL_W-1:0] right_raw;
    logic signed [lfs_pkg::WHEEL_W-1:0] left_clamp;
    logic signed [lfs_pkg::WHEEL_W-1:0] right_clamp;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = lfs_pkg::reg_idx_t'(paddr[lfs_pkg::ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_threshold_reg <= lfs_pkg::WHITE_THRESHOLD_RST;
            tape_width_reg      <= lfs_pkg::TAPE_WIDTH_RST;
            steer_gain_reg      <= lfs_pkg::STEER_GAIN_RST;
            base_speed_reg      <= lfs_pkg::BASE_SPEED_RST;
            speed_limit_reg     <= lfs_pkg::SPEED_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                lfs_pkg::REG_WHITE_THRESHOLD:
                    white_threshold_reg <= pwdata[lfs_pkg::BRIGHT_W-1:0];
                lfs_pkg::REG_TAPE_WIDTH:
                    tape_width_reg <= pwdata[lfs_pkg::TAPE_W-1:0];
                lfs_pkg::REG_STEER_GAIN:
                    steer_gain_reg <= pwdata[lfs_pkg::GAIN_W-1:0];
                lfs_pkg::REG_BASE_SPEED:
                    base_speed_reg <= pwdata[lfs_pkg::SPEED_W-1:0];
                lfs_pkg::REG_SPEED_LIMIT:
                    speed_limit_reg <= pwdata[lfs_pkg::SPEED_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            lfs_pkg::REG_WHITE_THRESHOLD:
                prdata = lfs_pkg::DATA_W'(white_threshold_reg);
            lfs_pkg::REG_TAPE_WIDTH:
                prdata = lfs_pkg::DATA_W'(tape_width_reg);
            lfs_pkg::REG_STEER_GAIN:
                prdata = lfs_pkg::DATA_W'(steer_gain_reg);
            lfs_pkg::REG_BASE_SPEED:
                prdata = lfs_pkg::DATA_W'(base_speed_reg);
            lfs_pkg::REG_SPEED_LIMIT:
                prdata = lfs_pkg::DATA_W'(speed_limit_reg);
            default:
                prdata = '0;
        endcase
    end

    // Pipeline flow control.
    assign out_ready = !out_valid_reg || m_tready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_tready  = s1_ready;
    assign in_accept = s_tvalid && s_tready;

    // Row accumulation. Pixels past the end of a full row are ignored.
    assign in_row      = (pos_reg < lfs_pkg::POS_W'(lfs_pkg::ROW_PIXELS));
    assign pixel_white = in_row && (s_tdata > white_threshold_reg);
    assign offset      = signed'(lfs_pkg::SUM_W'(pos_reg))
                         - signed'(lfs_pkg::SUM_W'(lfs_pkg::HALF_ROW));

    always_comb
    begin
        pos_next   = in_row ? pos_reg + 1'b1 : pos_reg;
        count_next = pixel_white ? count_reg + 1'b1 : count_reg;
        sum_next   = pixel_white ? sum_reg + offset : sum_reg;
        s1_lost_next = (lfs_pkg::CMP_W'({count_next, 1'b0})
                        < lfs_pkg::CMP_W'(tape_width_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else if (in_accept)
        begin
            if (s_tlast)
            begin
                pos_reg   <= '0;
                count_reg <= '0;
                sum_reg   <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                count_reg <= count_next;
                sum_reg   <= sum_next;
            end
        end
    end

    // Stage 1: closed row sums and the tape-lost decision.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_accept && s_tlast;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_sum_reg  <= sum_next;
            s1_lost_reg <= s1_lost_next;
        end
    end

    // Stage 2: gain multiplier.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_prod_reg <= lfs_pkg::PROD_W'(s1_sum_reg * signed'({1'b0, steer_gain_reg}));
            s2_lost_reg <= s1_lost_reg;
        end
    end

    // Stage 3: truncate toward zero, add to base speed (or reverse at base speed when the tape is lost) and clamp.
    always_comb
    begin
        steer = s2_prod_reg[lfs_pkg::PROD_W-1:lfs_pkg::GAIN_W];
        if (s2_prod_reg[lfs_pkg::PROD_W-1] && (s2_prod_reg[lfs_pkg::GAIN_W-1:0] != '0))
        begin
            steer = steer + 1'b1;
        end
        base_s = signed'(lfs_pkg::WHEEL_W'(base_speed_reg));
        lim_s  = signed'(lfs_pkg::WHEEL_W'(speed_limit_reg));
        if (s2_lost_reg)
        begin
            left_raw  = -base_s;
            right_raw = -base_s;
        end
        else
        begin
            left_raw  = base_s + lfs_pkg::WHEEL_W'(steer);
            right_raw = base_s - lfs_pkg::WHEEL_W'(steer);
        end
        if (left_raw > lim_s)
            left_clamp = lim_s;
        else if (left_raw < -lim_s)
            left_clamp = -lim_s;
        else
            left_clamp = left_raw;
        if (right_raw > lim_s)
            right_clamp = lim_s;
        else if (right_raw < -lim_s)
            right_clamp = -lim_s;
        else
            right_clamp = right_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            left_reg  <= left_clamp[lfs_pkg::OUT_W-1:0];
            right_reg <= right_clamp[lfs_pkg::OUT_W-1:0];
            rev_reg   <= s2_lost_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, right_reg, left_reg};
    assign m_tuser  = rev_reg;

endmodule

/* bench/tb_line_follow_steering_top.sv */
// Testbench for line_follow_steering_top: drives camera rows on the pixel stream,
// sets registers over the APB port and checks each wheel command against a predictor.
// Depends on lfs_pkg and the line_follow_steering_top RTL.
module tb_line_follow_steering_top;

    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic signed [8:0] left;
        logic signed [8:0] right;
        logic              rev;
    } wheel_cmd_t;

    class steering_scoreboard;
        logic [7:0]   white_thr;
        logic [9:0]   tape_w;
        logic [15:0]  gain;
        logic [7:0]   base_spd;
        logic [7:0]   speed_lim;
        int           pos;
        int           white_cnt;
        int           offset_sum;
        wheel_cmd_t   expected_cmds[$];
        int           mismatches;

        function new();
            white_thr  = lfs_pkg::WHITE_THRESHOLD_RST;
            tape_w     = lfs_pkg::TAPE_WIDTH_RST;
            gain       = lfs_pkg::STEER_GAIN_RST;
            base_spd   = lfs_pkg::BASE_SPEED_RST;
            speed_lim  = lfs_pkg::SPEED_LIMIT_RST;
            pos        = 0;
            white_cnt  = 0;
            offset_sum = 0;
            mismatches = 0;
        endfunction

        function void set_reg(lfs_pkg::reg_idx_t idx, logic [31:0] value);
            case (idx)
                lfs_pkg::REG_WHITE_THRESHOLD: white_thr = value[7:0];
                lfs_pkg::REG_TAPE_WIDTH:      tape_w    = value[9:0];
                lfs_pkg::REG_STEER_GAIN:      gain      = value[15:0];
                lfs_pkg::REG_BASE_SPEED:      base_spd  = value[7:0];
                lfs_pkg::REG_SPEED_LIMIT:     speed_lim = value[7:0];
                default:                      ;
            endcase
        endfunction

        function longint clamp_wheel(longint v);
            longint lim;
            lim = speed_lim;
            if (v > lim)
                return lim;
            if (v < -lim)
                return -lim;
            return v;
        endfunction

        function void note_pixel(logic [7:0] bright, logic last);
            longint     prod;
            longint     steer;
            longint     g;
            longint     b;
            longint     l;
            longint     r;
            wheel_cmd_t cmd;
            if (pos < lfs_pkg::ROW_PIXELS)
            begin
                if (bright > white_thr)
                begin
                    white_cnt++;
                    offset_sum += pos - lfs_pkg::HALF_ROW;
                end
                pos++;
            end
            if (!last)
                return;
            b = base_spd;
            if (2 * white_cnt < int'(tape_w))
            begin
                l = clamp_wheel(-b);
                r = l;
                cmd.rev = 1'b1;
            end
            else
            begin
                g = gain;
                prod = offset_sum;
                prod = prod * g;
                if (prod < 0)
                    steer = -((-prod) / 65536);
                else
                    steer = prod / 65536;
                l = clamp_wheel(b + steer);
                r = clamp_wheel(b - steer);
                cmd.rev = 1'b0;
            end
            cmd.left  = l[8:0];
            cmd.right = r[8:0];
            expected_cmds.push_back(cmd);
            pos        = 0;
            white_cnt  = 0;
            offset_sum = 0;
        endfunction

        function void flag_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function void check_wheels(logic [8:0] l, logic [8:0] r, logic rev);
            wheel_cmd_t want;
            if (expected_cmds.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected item: left %0d right %0d rev %0d",
                    $signed(l), $signed(r), rev));
                return;
            end
            want = expected_cmds.pop_front();
            if (want.left !== l || want.right !== r || want.rev !== rev)
                flag_mismatch($sformatf(
                    "mismatch: expected left %0d right %0d rev %0d, got left %0d right %0d rev %0d",
                    want.left, want.right, want.rev, $signed(l), $signed(r), rev));
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction

        function void close_out();
            if (expected_cmds.size() != 0)
                flag_mismatch($sformatf("%0d expected items never arrived",
                    expected_cmds.size()));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] pixel_brightness
    logic        s_tlast;   // row_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;   // [8:0] left_speed, [17:9] right_speed
    logic        m_tuser;   // reversing
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [lfs_pkg::ADDR_W-1:0] paddr;
    logic [lfs_pkg::DATA_W-1:0] pwdata;
    logic [lfs_pkg::DATA_W-1:0] prdata;
    logic        pready;

    steering_scoreboard sb;
    bit          calm;
    int          stall_count;
    int          items_sent;

    line_follow_steering_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        m_tready <= calm || ($urandom_range(0, 99) >= 16);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_pixel(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_wheels(m_tdata[8:0], m_tdata[17:9], m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("line_follow_steering_top test failed");
                $finish;
            end
        end
    end

    task automatic send_pixel(logic [7:0] bright, logic last);
        while (!calm && $urandom_range(0, 99) < 16)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= bright;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    task automatic send_row(int len, bit tape_like);
        int         start;
        int         width;
        int         t;
        logic [7:0] b;
        t = sb.white_thr;
        start = $urandom_range(0, len - 1);
        width = $urandom_range(1, len);
        for (int i = 0; i < len; i++)
        begin
            if (!tape_like)
                b = $urandom_range(0, 255);
            else if (i >= start && i < start + width)
                b = $urandom_range((t < 255) ? t + 1 : 255, 255);
            else
                b = $urandom_range(0, t);
            send_pixel(b, i == len - 1);
        end
    endtask

    task automatic run_rows(int budget);
        int goal;
        int len;
        goal = items_sent + budget;
        while (items_sent < goal)
        begin
            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(25, 64);
            else
                len = $urandom_range(1, 24);
            send_row(len, $urandom_range(0, 2) != 0);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(lfs_pkg::reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic apply_settings(int thr, int tape, int g, int base, int lim);
        drain_results();
        repeat (6) @(posedge clk);
        write_reg(lfs_pkg::REG_WHITE_THRESHOLD, thr);
        write_reg(lfs_pkg::REG_TAPE_WIDTH, tape);
        write_reg(lfs_pkg::REG_STEER_GAIN, g);
        write_reg(lfs_pkg::REG_BASE_SPEED, base);
        write_reg(lfs_pkg::REG_SPEED_LIMIT, lim);
    endtask

    task automatic random_settings(int tape_max);
        apply_settings($urandom_range(0, 255), $urandom_range(0, tape_max),
            $urandom_range(0, 65535), $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    initial
    begin
        sb = new();
        calm        = 1'b0;
        stall_count = 0;
        items_sent  = 0;
        rst_n    = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default settings: a one-pixel row and a short row around the threshold.
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd100, 1'b0);
        send_pixel(8'd101, 1'b0);
        send_pixel(8'd255, 1'b1);

        apply_settings(0, 0, 65535, 255, 255);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd0, 1'b1);
        run_rows(45);

        apply_settings(255, 640, 0, 0, 0);
        send_pixel(8'd255, 1'b1);
        run_rows(45);

        // Every pixel white across a full row sits exactly at the tape width.
        apply_settings(0, 640, 65535, 100, 200);
        for (int i = 0; i < lfs_pkg::ROW_PIXELS; i++)
        begin
            send_pixel(8'd255, i == lfs_pkg::ROW_PIXELS - 1);
        end
        run_rows(25);

        apply_settings(128, 4, 4096, 200, 120);
        run_rows(45);

        calm = 1'b1;
        random_settings(40);
        run_rows(45);
        calm = 1'b0;

        random_settings(40);
        run_rows(25);
        drain_results();
        run_rows(20);

        random_settings(640);
        run_rows(45);

        // A row longer than the camera line with a tape at a random place.
        apply_settings(100, 60, 164, 40, 150);
        send_row(lfs_pkg::ROW_PIXELS + 10, 1'b1);
        run_rows(45);

        random_settings(30);
        run_rows(45);

        drain_results();
        repeat (10) @(posedge clk);
        sb.close_out();
        if (sb.mismatches == 0)
            $display("line_follow_steering_top test passed");
        else
            $display("line_follow_steering_top test failed");
        $finish;
    end

endmodule
